>>> hdl/bpg_pkg.sv
// Shared types, control codes and the microcode table of the partition generator.
package bpg_pkg;

	localparam int MAX_TOTAL = 32;
	localparam int VAL_W     = 6;
	localparam int CNT_W     = $clog2(MAX_TOTAL + 1);
	localparam int ADDR_W    = $clog2(MAX_TOTAL);
	localparam int PC_W      = 4;
	localparam int OP_W      = 4;
	localparam int COND_W    = 4;
	localparam int TDATA_W   = 8;

	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [PC_W-1:0]   pc_t;

	// configuration register indexes
	localparam logic CFG_TOTAL    = 1'b0;
	localparam logic CFG_MAX_PART = 1'b1;

	// datapath operations
	localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
	localparam logic [OP_W-1:0] OP_WAIT      = 4'd1;
	localparam logic [OP_W-1:0] OP_RD_TOP    = 4'd2;
	localparam logic [OP_W-1:0] OP_POP       = 4'd3;
	localparam logic [OP_W-1:0] OP_DEC       = 4'd4;
	localparam logic [OP_W-1:0] OP_INIT      = 4'd5;
	localparam logic [OP_W-1:0] OP_FILL      = 4'd6;
	localparam logic [OP_W-1:0] OP_EMIT_INIT = 4'd7;
	localparam logic [OP_W-1:0] OP_EMIT      = 4'd8;
	localparam logic [OP_W-1:0] OP_EXH       = 4'd9;

	// jump conditions
	localparam logic [COND_W-1:0] C_ALWAYS    = 4'd0;
	localparam logic [COND_W-1:0] C_NO_ACC    = 4'd1;
	localparam logic [COND_W-1:0] C_RESTART   = 4'd2;
	localparam logic [COND_W-1:0] C_DONE      = 4'd3;
	localparam logic [COND_W-1:0] C_CNT_ZERO  = 4'd4;
	localparam logic [COND_W-1:0] C_POP_MORE  = 4'd5;
	localparam logic [COND_W-1:0] C_BAD       = 4'd6;
	localparam logic [COND_W-1:0] C_FILL_MORE = 4'd7;
	localparam logic [COND_W-1:0] C_EMIT_STAY = 4'd8;
	localparam logic [COND_W-1:0] C_OUT_BUSY  = 4'd9;

	// program addresses
	localparam pc_t PC_WAIT  = 4'd0;
	localparam pc_t PC_SEL_R = 4'd1;
	localparam pc_t PC_SEL_D = 4'd2;
	localparam pc_t PC_RDTOP = 4'd3;
	localparam pc_t PC_POP   = 4'd4;
	localparam pc_t PC_CHK   = 4'd5;
	localparam pc_t PC_DEC   = 4'd6;
	localparam pc_t PC_INIT  = 4'd7;
	localparam pc_t PC_FILL  = 4'd8;
	localparam pc_t PC_EMIT0 = 4'd9;
	localparam pc_t PC_EMIT  = 4'd10;
	localparam pc_t PC_EDONE = 4'd11;
	localparam pc_t PC_EXH   = 4'd12;
	localparam pc_t PC_XDONE = 4'd13;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [COND_W-1:0] cond;
		pc_t               target;
	} ctrl_t;

	typedef struct packed {
		logic accept;
		logic restart;
		logic done;
		logic cnt_zero;
		logic bad_cfg;
		logic pop_more;
		logic fill_more;
		logic emit_stay;
		logic out_busy;
	} stat_t;

	// one control word per step: jump to target when the condition holds, else advance
	function automatic ctrl_t ucode(input pc_t pc);
		ctrl_t w;
		unique case (pc)
			PC_WAIT:  w = '{OP_WAIT,      C_NO_ACC,    PC_WAIT};
			PC_SEL_R: w = '{OP_NOP,       C_RESTART,   PC_INIT};
			PC_SEL_D: w = '{OP_NOP,       C_DONE,      PC_EXH};
			PC_RDTOP: w = '{OP_RD_TOP,    C_CNT_ZERO,  PC_EXH};
			PC_POP:   w = '{OP_POP,       C_POP_MORE,  PC_POP};
			PC_CHK:   w = '{OP_NOP,       C_CNT_ZERO,  PC_EXH};
			PC_DEC:   w = '{OP_DEC,       C_ALWAYS,    PC_FILL};
			PC_INIT:  w = '{OP_INIT,      C_BAD,       PC_EXH};
			PC_FILL:  w = '{OP_FILL,      C_FILL_MORE, PC_FILL};
			PC_EMIT0: w = '{OP_EMIT_INIT, C_ALWAYS,    PC_EMIT};
			PC_EMIT:  w = '{OP_EMIT,      C_EMIT_STAY, PC_EMIT};
			PC_EDONE: w = '{OP_NOP,       C_ALWAYS,    PC_WAIT};
			PC_EXH:   w = '{OP_EXH,       C_OUT_BUSY,  PC_EXH};
			PC_XDONE: w = '{OP_NOP,       C_ALWAYS,    PC_WAIT};
			default:  w = '{OP_NOP,       C_ALWAYS,    PC_WAIT};
		endcase
		return w;
	endfunction

endpackage

>>> hdl/bpg_sequencer.sv
// Step counter, microcode fetch and conditional jump logic.
module bpg_sequencer (
	input  logic           clk,
	input  logic           arst_n,
	input  bpg_pkg::stat_t stat,
	output bpg_pkg::ctrl_t ctrl
);

	bpg_pkg::pc_t pc_q;
	logic         take;

	assign ctrl = bpg_pkg::ucode(pc_q);

	always_comb begin
		unique case (ctrl.cond)
			bpg_pkg::C_ALWAYS:    take = 1'b1;
			bpg_pkg::C_NO_ACC:    take = ~stat.accept;
			bpg_pkg::C_RESTART:   take = stat.restart;
			bpg_pkg::C_DONE:      take = stat.done;
			bpg_pkg::C_CNT_ZERO:  take = stat.cnt_zero;
			bpg_pkg::C_POP_MORE:  take = stat.pop_more;
			bpg_pkg::C_BAD:       take = stat.bad_cfg;
			bpg_pkg::C_FILL_MORE: take = stat.fill_more;
			bpg_pkg::C_EMIT_STAY: take = stat.emit_stay;
			bpg_pkg::C_OUT_BUSY:  take = stat.out_busy;
			default:              take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= bpg_pkg::PC_WAIT;
		end else if (take) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= pc_q + bpg_pkg::pc_t'(1);
		end
	end

endmodule

>>> hdl/bpg_datapath.sv
// Partition store, working counters and the output register.
module bpg_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bpg_pkg::ctrl_t              ctrl,
	input  bpg_pkg::val_t               total,
	input  bpg_pkg::val_t               max_part,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [bpg_pkg::TDATA_W-1:0] s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [bpg_pkg::TDATA_W-1:0] m_tdata,
	output logic                        m_tlast,
	output logic                        m_tuser,
	output bpg_pkg::stat_t              stat
);

	bpg_pkg::val_t  mem [bpg_pkg::MAX_TOTAL];
	bpg_pkg::val_t  rd_q;

	logic           started_q, done_q, rs_q;
	bpg_pkg::cnt_t  cnt_q, idx_q;
	bpg_pkg::val_t  rem_q, lim_q;

	logic           out_v_q, out_last_q, out_exh_q;
	bpg_pkg::val_t  out_val_q;

	logic           accept, out_busy, top_le1, fill_end, emit_last, pop_do, load;
	bpg_pkg::val_t  fill_p, init_lim;
	bpg_pkg::cnt_t  cnt_m1, cnt_m2, idx_nxt;
	logic           rd_en, wr_en;
	bpg_pkg::addr_t rd_addr, wr_addr;
	bpg_pkg::val_t  wr_data;

	assign s_tready  = (ctrl.op == bpg_pkg::OP_WAIT);
	assign accept    = s_tvalid & s_tready;
	assign out_busy  = out_v_q & ~m_tready;
	assign top_le1   = (rd_q <= bpg_pkg::val_t'(1));
	assign fill_end  = (rem_q == '0) || (lim_q == '0) ||
	                   (cnt_q == bpg_pkg::cnt_t'(bpg_pkg::MAX_TOTAL));
	assign fill_p    = (lim_q < rem_q) ? lim_q : rem_q;
	assign init_lim  = (max_part < total) ? max_part : total;
	assign cnt_m1    = cnt_q - bpg_pkg::cnt_t'(1);
	assign cnt_m2    = cnt_q - bpg_pkg::cnt_t'(2);
	assign idx_nxt   = idx_q + bpg_pkg::cnt_t'(1);
	assign emit_last = (idx_nxt == cnt_q);
	assign pop_do    = top_le1 & (cnt_q != '0);
	assign load      = ((ctrl.op == bpg_pkg::OP_EMIT) || (ctrl.op == bpg_pkg::OP_EXH)) &
	                   ~out_busy;

	assign stat.accept    = accept;
	assign stat.restart   = rs_q;
	assign stat.done      = done_q;
	assign stat.cnt_zero  = (cnt_q == '0);
	assign stat.bad_cfg   = (total == '0) || (max_part == '0) ||
	                        (int'(total) > bpg_pkg::MAX_TOTAL);
	assign stat.pop_more  = top_le1 & (cnt_q > bpg_pkg::cnt_t'(1));
	assign stat.fill_more = ~fill_end;
	assign stat.emit_stay = out_busy | ~emit_last;
	assign stat.out_busy  = out_busy;

	// store port selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = cnt_q[bpg_pkg::ADDR_W-1:0];
		wr_data = fill_p;
		unique case (ctrl.op)
			bpg_pkg::OP_RD_TOP: begin
				rd_en   = 1'b1;
				rd_addr = cnt_m1[bpg_pkg::ADDR_W-1:0];
			end
			bpg_pkg::OP_POP: begin
				rd_en   = pop_do;
				rd_addr = cnt_m2[bpg_pkg::ADDR_W-1:0];
			end
			bpg_pkg::OP_DEC: begin
				wr_en   = 1'b1;
				wr_addr = cnt_m1[bpg_pkg::ADDR_W-1:0];
				wr_data = rd_q - bpg_pkg::val_t'(1);
			end
			bpg_pkg::OP_FILL: begin
				wr_en   = ~fill_end;
			end
			bpg_pkg::OP_EMIT_INIT: begin
				rd_en   = 1'b1;
			end
			bpg_pkg::OP_EMIT: begin
				rd_en   = ~out_busy;
				rd_addr = idx_nxt[bpg_pkg::ADDR_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			done_q    <= 1'b0;
			rs_q      <= 1'b0;
			cnt_q     <= '0;
			idx_q     <= '0;
			rem_q     <= '0;
			lim_q     <= '0;
		end else begin
			unique case (ctrl.op)
				bpg_pkg::OP_WAIT: begin
					if (accept) begin
						rs_q <= s_tdata[0] | ~started_q;
					end
				end
				bpg_pkg::OP_RD_TOP: begin
					rem_q <= '0;
				end
				bpg_pkg::OP_POP: begin
					if (pop_do) begin
						cnt_q <= cnt_m1;
						rem_q <= rem_q + rd_q;
					end
				end
				bpg_pkg::OP_DEC: begin
					lim_q <= rd_q - bpg_pkg::val_t'(1);
					rem_q <= rem_q + bpg_pkg::val_t'(1);
				end
				bpg_pkg::OP_INIT: begin
					started_q <= 1'b1;
					done_q    <= 1'b0;
					cnt_q     <= '0;
					rem_q     <= total;
					lim_q     <= init_lim;
				end
				bpg_pkg::OP_FILL: begin
					if (!fill_end) begin
						cnt_q <= cnt_q + bpg_pkg::cnt_t'(1);
						rem_q <= rem_q - fill_p;
					end
				end
				bpg_pkg::OP_EMIT_INIT: begin
					idx_q <= '0;
				end
				bpg_pkg::OP_EMIT: begin
					if (!out_busy) begin
						idx_q <= idx_nxt;
					end
				end
				bpg_pkg::OP_EXH: begin
					if (!out_busy) begin
						done_q <= 1'b1;
						cnt_q  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (ctrl.op == bpg_pkg::OP_EXH) begin
				out_val_q  <= '0;
				out_last_q <= 1'b1;
				out_exh_q  <= 1'b1;
			end else begin
				out_val_q  <= rd_q;
				out_last_q <= emit_last;
				out_exh_q  <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {{(bpg_pkg::TDATA_W - bpg_pkg::VAL_W){1'b0}}, out_val_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_exh_q;

endmodule

>>> hdl/bounded_partition_generator.sv
// Top level: enumerates bounded integer partitions, one partition per request beat.
// Request kinds: restart (P parts), next (D trailing ones dropped, F parts refilled), and
//   exhausted, either directly or after dropping D ones.
// Output stalls add delay; fill and emit loops walk the store one entry per cycle,
//   the emit loop holding while the output is stalled.
// Reset: arst_n clears sequencer, counters and flags; total and max_part return to 1.
module bounded_partition_generator (
	input  logic                        clk,
	input  logic                        arst_n,
	// request side
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [bpg_pkg::TDATA_W-1:0] s_tdata,   // [0] restart, [7:1] zero
	// result side
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [bpg_pkg::TDATA_W-1:0] m_tdata,   // [5:0] part_value, [7:6] zero
	output logic                        m_tlast,   // last_part
	output logic                        m_tuser,   // [0] exhausted
	// configuration writes: index 0 total, index 1 max_part
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  bpg_pkg::val_t               cfg_data
);

	bpg_pkg::val_t  total_q, max_part_q;
	bpg_pkg::ctrl_t ctrl;
	bpg_pkg::stat_t stat;

	// Hold the configuration; it takes effect at the next restart because the
	// successor steps work only on the stored partition.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= bpg_pkg::val_t'(1);
			max_part_q <= bpg_pkg::val_t'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				bpg_pkg::CFG_TOTAL:    total_q    <= cfg_data;
				bpg_pkg::CFG_MAX_PART: max_part_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Microcoded control: the sequencer steps through the program, jumping on
	// status flags; the datapath executes one operation per control word.
	bpg_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// Datapath: drop trailing ones, decrement the rightmost part above one,
	// refill greedily, then stream the stored parts out through one output
	// register, so a result beat may wait while the next request is taken.
	// The partition store has no reset; any read past the part count is never emitted.
	bpg_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.total    (total_q),
		.max_part (max_part_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.stat     (stat)
	);

	// An exhausted beat carries a zero part and closes its run.
	a_exh_form: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0) && m_tlast)
		else $error("exhausted beat malformed");

	// A real part is never zero.
	a_part_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata != '0))
		else $error("zero part emitted");

	// Once a request is taken the sequencer leaves the wait step.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while busy");

endmodule
